// ===== hw/rtl/mort_pkg.sv =====
// shared types and constants for the midi octave retrigger filter
// no dependencies
package mort_pkg;

	localparam int NUM_KEYS = 128;
	localparam int KEY_W    = $clog2(NUM_KEYS);

	localparam logic [7:0] ST_NOTE_ON    = 8'h90;
	localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
	localparam logic [7:0] ST_CTRL       = 8'hB0;
	localparam logic [7:0] CTRL_DAMPER   = 8'h40;
	localparam logic [6:0] PEDAL_ON_VAL  = 7'h7F;
	localparam logic [6:0] RETRIGGER_MIN = 7'd50;
	localparam logic [6:0] OCTAVE        = 7'd12;
	localparam logic [6:0] RELEASE_VAL   = 7'd64;
	localparam logic [7:0] KEY_LIMIT     = 8'(NUM_KEYS);

	typedef logic [KEY_W-1:0] key_t;

	typedef enum logic [1:0] {
		KIND_PEDAL,
		KIND_ON,
		KIND_OFF
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] note;
		logic [6:0] value;
		logic       retrig;
	} cmd_t;

endpackage

// ===== hw/rtl/midi_octave_retrigger_filter_core.sv =====
// midi octave retrigger filter top level
// path: input to command queue to output register, via ST_LOOK for a retrigger
// throughput: one input per cycle while the output is not stalled and no retrigger
// run is active, set by the sequencer sharing one memory port and the output register
// reset: channel 0, all held keys read as zero, no clearing pass
module midi_octave_retrigger_filter_core import mort_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] status_byte,
	input  logic [7:0] first_data,
	input  logic [6:0] second_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_status,
	output logic [6:0] out_note,
	output logic [6:0] out_value,
	output logic       last_of_run
);

	logic [3:0] midi_channel_q;
	logic       q_full;
	logic       q_push;
	logic       q_pop;
	logic       q_not_empty;
	cmd_t       q_cmd;
	cmd_t       q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midi_channel_q <= 4'd0;
		end else if (cfg_valid) begin
			midi_channel_q <= cfg_data;
		end
	end

	mort_front u_front (
		.midi_channel (midi_channel_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.status_byte  (status_byte),
		.first_data   (first_data),
		.second_data  (second_data),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (q_cmd)
	);

	mort_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	mort_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.midi_channel (midi_channel_q),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_status   (out_status),
		.out_note     (out_note),
		.out_value    (out_value),
		.last_of_run  (last_of_run)
	);

endmodule

// ===== hw/rtl/mort_front.sv =====
// front end: classifies incoming midi messages into queue commands
// depends on mort_pkg
module mort_front import mort_pkg::*; (
	input  logic [3:0] midi_channel,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] status_byte,
	input  logic [7:0] first_data,
	input  logic [6:0] second_data,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	logic is_pedal;
	logic in_range;
	logic is_on;
	logic is_off;

	always_comb begin
		is_pedal = (status_byte == ST_CTRL) && (first_data == CTRL_DAMPER);
		in_range = first_data < KEY_LIMIT;
		is_on    = status_byte == {ST_NOTE_ON[7:4], midi_channel};
		is_off   = status_byte == {ST_NOTE_OFF[7:4], midi_channel};

		q_cmd.note   = first_data[6:0];
		q_cmd.retrig = (first_data[6:0] >= OCTAVE) && (second_data >= RETRIGGER_MIN);
		if (is_pedal) begin
			q_cmd.kind  = KIND_PEDAL;
			q_cmd.value = (second_data != 7'd0) ? PEDAL_ON_VAL : 7'd0;
		end else if (is_on) begin
			q_cmd.kind  = KIND_ON;
			q_cmd.value = second_data;
		end else begin
			q_cmd.kind  = KIND_OFF;
			q_cmd.value = RELEASE_VAL;
		end

		in_ready = !q_full;
		// dropped messages are accepted but never queued
		q_push   = in_valid && !q_full && (is_pedal || (in_range && (is_on || is_off)));
	end

endmodule

// ===== hw/rtl/mort_queue.sv =====
// two-entry command queue between the front end and the back end
// depends on mort_pkg
module mort_queue import mort_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/mort_back.sv =====
// back end: held-velocity memory, retrigger sequencer and output register
// depends on mort_pkg
module mort_back import mort_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [3:0] midi_channel,
	input  logic       q_not_empty,
	input  cmd_t       q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_status,
	output logic [6:0] out_note,
	output logic [6:0] out_value,
	output logic       last_of_run
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_OFF,
		ST_ON
	} state_t;

	state_t     state_q;
	cmd_t       cur_q;
	logic [6:0] mem_q [NUM_KEYS];
	logic [NUM_KEYS-1:0] vld_q;
	logic [6:0] rdata_s1;
	logic       rvld_s1;

	logic       out_free;
	logic [7:0] on_st;
	logic [7:0] off_st;
	logic [6:0] head_lo;
	logic [6:0] cur_lo;
	logic [6:0] new_vel;
	logic [6:0] lower_vel;
	logic       wr_en;
	logic       clr_en;
	key_t       wr_addr;
	logic [6:0] wr_data;

	always_comb begin
		out_free  = !out_valid || out_ready;
		on_st     = {ST_NOTE_ON[7:4], midi_channel};
		off_st    = {ST_NOTE_OFF[7:4], midi_channel};
		head_lo   = q_head.note - OCTAVE;
		cur_lo    = cur_q.note - OCTAVE;
		new_vel   = cur_q.value - RETRIGGER_MIN;
		lower_vel = rvld_s1 ? rdata_s1 : 7'd0;
		q_pop     = (state_q == ST_IDLE) && q_not_empty && out_free;

		wr_en   = 1'b0;
		clr_en  = 1'b0;
		wr_addr = q_head.note[KEY_W-1:0];
		wr_data = q_head.value;
		if (q_pop) begin
			wr_en  = q_head.kind == KIND_ON;
			clr_en = q_head.kind == KIND_OFF;
		end else if (state_q == ST_LOOK && out_free && lower_vel != 7'd0) begin
			wr_en   = 1'b1;
			wr_addr = cur_lo[KEY_W-1:0];
			wr_data = new_vel;
		end
	end

	// velocity store; a lookup reads as zero unless vld_q marks the key as written since reset or its last note off
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (q_pop) begin
			rdata_s1 <= mem_q[head_lo[KEY_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end else if (clr_en) begin
				vld_q[wr_addr] <= 1'b0;
			end
			if (q_pop) begin
				rvld_s1 <= vld_q[head_lo[KEY_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			out_valid   <= 1'b0;
			out_status  <= '0;
			out_note    <= '0;
			out_value   <= '0;
			last_of_run <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						cur_q <= q_head;
						case (q_head.kind)
							KIND_PEDAL: begin
								out_valid   <= 1'b1;
								out_status  <= ST_CTRL;
								out_note    <= CTRL_DAMPER[6:0];
								out_value   <= q_head.value;
								last_of_run <= 1'b1;
							end
							KIND_ON: begin
								if (q_head.retrig) begin
									state_q <= ST_LOOK;
								end else begin
									out_valid   <= 1'b1;
									out_status  <= on_st;
									out_note    <= q_head.note;
									out_value   <= q_head.value;
									last_of_run <= 1'b1;
								end
							end
							default: begin
								out_valid   <= 1'b1;
								out_status  <= off_st;
								out_note    <= q_head.note;
								out_value   <= RELEASE_VAL;
								last_of_run <= 1'b1;
							end
						endcase
					end
				end
				ST_LOOK: begin
					if (out_free) begin
						out_valid  <= 1'b1;
						out_status <= on_st;
						out_note   <= cur_q.note;
						out_value  <= cur_q.value;
						if (lower_vel != 7'd0) begin
							last_of_run <= 1'b0;
							state_q     <= ST_OFF;
						end else begin
							last_of_run <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
				end
				ST_OFF: begin
					if (out_free) begin
						out_valid   <= 1'b1;
						out_status  <= off_st;
						out_note    <= cur_lo;
						out_value   <= RELEASE_VAL;
						last_of_run <= 1'b0;
						state_q     <= ST_ON;
					end
				end
				ST_ON: begin
					if (out_free) begin
						out_valid   <= 1'b1;
						out_status  <= on_st;
						out_note    <= cur_lo;
						out_value   <= new_vel;
						last_of_run <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
